// ===== hw/rtl/ps2t_pkg.sv =====
package ps2t_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned OUT_W   = 12;
  localparam int unsigned DELTA_W = 11;
  localparam int unsigned SUM_W   = 14;

  localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes.
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_t;

  // What the framer knows about the byte now at its input.
  typedef struct packed {
    logic              third;
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] xbyte;
  } pkt_t;

endpackage

// ===== hw/rtl/ps2t_framer.sv =====
module ps2t_framer
  import ps2t_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_fire,
  input  logic [BYTE_W-1:0] byte_in,
  output pkt_t              pkt
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] header_r, header_nxt;
  logic [BYTE_W-1:0] xbyte_r, xbyte_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    xbyte_nxt  = xbyte_r;
    if (byte_fire) begin
      unique case (phase_r)
        PH_X: begin
          xbyte_nxt = byte_in;
          phase_nxt = PH_Y;
        end
        PH_Y: begin
          phase_nxt = PH_HEAD;
        end
        default: begin
          // A first byte must carry the always-one bit, otherwise it is dropped.
          if (byte_in[3]) begin
            header_nxt = byte_in;
            phase_nxt  = PH_X;
          end else begin
            phase_nxt = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_comb begin
    pkt.third  = (phase_r == PH_Y);
    pkt.header = header_r;
    pkt.xbyte  = xbyte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD;
      header_r <= '0;
      xbyte_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      xbyte_r  <= xbyte_nxt;
    end
  end

endmodule

// ===== hw/rtl/ps2t_axis.sv =====
module ps2t_axis
  import ps2t_pkg::*;
#(
  parameter int unsigned CURSOR = 8
) (
  input  logic [POS_W-1:0]          pos,
  input  logic signed [DELTA_W-1:0] delta,
  input  logic [DIM_W-1:0]          dim,
  output logic [POS_W-1:0]          pos_new
);

  localparam logic [DIM_W-1:0] CURSOR_C = DIM_W'(CURSOR);

  logic [DIM_W-1:0]        dim_c;
  logic [POS_W-1:0]        hi;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    dim_c = (dim > DIM_LIMIT) ? DIM_LIMIT : dim;
    hi    = (dim_c > CURSOR_C) ? POS_W'(dim_c - CURSOR_C) : '0;
    sum   = $signed({1'b0, pos}) + SUM_W'(delta);
    if (sum < 0) begin
      pos_new = '0;
    end else if (sum[POS_W-1:0] > hi) begin
      pos_new = hi;
    end else begin
      pos_new = sum[POS_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/ps2_mouse_packet_tracker_top.sv =====
// PS/2 mouse packet tracker. Mouse bytes arrive one word at a time on the in_
// stream; they are framed into three-byte packets (a header is taken only when
// its bit 3 is set), and on each packet's third byte the X and Y deltas, with
// sign and overflow, move a cursor that is clamped to
// 0..screen_width-CURSOR_WIDTH and 0..screen_height-CURSOR_HEIGHT (sizes capped
// at 4096, bounds not below 0; down is positive). One word is made per complete
// packet, holding the position and the three buttons. One byte is taken per
// cycle unless a third byte waits for room in the output register; bytes pass
// an input register and the result is registered as the third byte leaves it,
// after one add and clamp per axis. Write screen_width and screen_height only
// while the stream is idle; a new value applies at the next packet.
module ps2_mouse_packet_tracker_top
  import ps2t_pkg::*;
#(
  parameter int unsigned CURSOR_WIDTH  = 8,
  parameter int unsigned CURSOR_HEIGHT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // [11:0] cursor_x, [23:12] cursor_y,
                                       // [24] left_button, [25] middle_button,
                                       // [26] right_button, [31:27] zero
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [DIM_W-1:0] cfg_wdata
);

  logic [DIM_W-1:0]   width_r, height_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               in_acc, out_free, s1_fire, pkt_done;
  pkt_t               pkt;

  logic [POS_W-1:0]          pos_x_r, pos_y_r, pos_x_new, pos_y_new;
  logic signed [DELTA_W-1:0] dx, dy, dy_neg;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;

  function automatic logic signed [DELTA_W-1:0] decode_delta(
    input logic [BYTE_W-1:0] mag,
    input logic              neg,
    input logic              ovf
  );
    logic signed [DELTA_W-1:0] d;
    begin
      if (neg) begin
        d = $signed({{(DELTA_W-BYTE_W){1'b1}}, mag});
        if (ovf) d = d - DELTA_W'(255);
      end else begin
        d = $signed({{(DELTA_W-BYTE_W){1'b0}}, mag});
        if (ovf) d = d + DELTA_W'(255);
      end
      return d;
    end
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A byte that closes a packet needs room in the output register; any other
  // byte only moves the framer and always proceeds.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!pkt.third || out_free);
  assign pkt_done  = s1_fire && pkt.third;
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)       s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_byte_r <= in_tdata;
  end

  ps2t_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (s1_fire),
    .byte_in   (s1_byte_r),
    .pkt       (pkt)
  );

  assign dx     = decode_delta(pkt.xbyte, pkt.header[4], pkt.header[6]);
  assign dy     = decode_delta(s1_byte_r, pkt.header[5], pkt.header[7]);
  assign dy_neg = -dy;

  ps2t_axis #(.CURSOR(CURSOR_WIDTH)) u_axis_x (
    .pos     (pos_x_r),
    .delta   (dx),
    .dim     (width_r),
    .pos_new (pos_x_new)
  );

  ps2t_axis #(.CURSOR(CURSOR_HEIGHT)) u_axis_y (
    .pos     (pos_y_r),
    .delta   (dy_neg),
    .dim     (height_r),
    .pos_new (pos_y_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
    end else if (pkt_done) begin
      pos_x_r <= pos_x_new;
      pos_y_r <= pos_y_new;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pkt_done)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done) begin
      out_data_r <= {5'b0, pkt.header[2:0], pos_y_new[OUT_W-1:0], pos_x_new[OUT_W-1:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A packet never completes onto a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_done |-> (!out_valid_r || out_tready))
    else $error("packet completed while output word was stalled");

  // A new result only ever follows a completed packet.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pkt_done))
    else $error("output word appeared without a completed packet");

  // The clamp keeps both positions inside the 12-bit output range.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!pos_x_r[POS_W-1] && !pos_y_r[POS_W-1]))
    else $error("cursor position out of range");

endmodule

// ===== tb/ps2_mouse_packet_tracker_checker.sv =====
`timescale 1ns / 100ps

// Watches the byte stream, the cursor stream and the register port of the packet
// tracker. It keeps its own copy of the framing state, the cursor position and
// the screen size, predicts each cursor word and compares it field by field.
module ps2_mouse_packet_tracker_checker
  import ps2t_pkg::*;
#(
  parameter int unsigned CURSOR_WIDTH  = 8,
  parameter int unsigned CURSOR_HEIGHT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [31:0]      out_tdata,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [DIM_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending,
  output int               reports_seen
);

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             left;
    logic             middle;
    logic             right;
  } cursor_report_t;

  cursor_report_t    cursor_reports[$];

  phase_t            frame_phase;
  logic [BYTE_W-1:0] head_byte;
  logic [BYTE_W-1:0] dx_byte;
  logic [POS_W-1:0]  cur_x;
  logic [POS_W-1:0]  cur_y;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;

  // Nine-bit two's complement movement, stretched by 255 on overflow.
  function automatic int signed_motion(logic [7:0] mag, logic neg, logic ovf);
    int d;
    if (neg) begin
      d = int'(mag) - 256;
      if (ovf) d = d - 255;
    end else begin
      d = int'(mag);
      if (ovf) d = d + 255;
    end
    return d;
  endfunction

  function automatic logic [POS_W-1:0] limit_axis(int p, logic [DIM_W-1:0] dim, int cursor);
    int span;
    int hi;
    span = (dim > DIM_LIMIT) ? int'(DIM_LIMIT) : int'(dim);
    hi = (span > cursor) ? span - cursor : 0;
    if (p < 0) return '0;
    if (p > hi) return POS_W'(hi);
    return POS_W'(p);
  endfunction

  // Advances the framing state by one mouse byte; returns 1 when a packet closes.
  function automatic bit track_byte(logic [7:0] b, output cursor_report_t rep);
    int dx;
    int dy;
    rep = '0;
    case (frame_phase)
      PH_X: begin
        dx_byte = b;
        frame_phase = PH_Y;
        return 1'b0;
      end
      PH_Y: begin
        frame_phase = PH_HEAD;
        dx = signed_motion(dx_byte, head_byte[4], head_byte[6]);
        dy = signed_motion(b, head_byte[5], head_byte[7]);
        cur_x = limit_axis(int'(cur_x) + dx, width_reg, CURSOR_WIDTH);
        cur_y = limit_axis(int'(cur_y) - dy, height_reg, CURSOR_HEIGHT);
        rep.x = cur_x[OUT_W-1:0];
        rep.y = cur_y[OUT_W-1:0];
        rep.left = head_byte[0];
        rep.middle = head_byte[1];
        rep.right = head_byte[2];
        return 1'b1;
      end
      default: begin
        if (b[3]) begin
          head_byte = b;
          frame_phase = PH_X;
        end else begin
          frame_phase = PH_HEAD;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t rep;
    cursor_report_t want;
    if (!rst_n) begin
      cursor_reports.delete();
      mismatches = 0;
      reports_seen = 0;
      frame_phase = PH_HEAD;
      head_byte = '0;
      dx_byte = '0;
      cur_x = '0;
      cur_y = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SCREEN_WIDTH:  width_reg = cfg_wdata;
          CFG_SCREEN_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (cursor_reports.size() == 0) begin
          $display("%0t: unexpected cursor word, expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = cursor_reports.pop_front();
          report_field("cursor_x", want.x, out_tdata[11:0]);
          report_field("cursor_y", want.y, out_tdata[23:12]);
          report_field("left_button", want.left, out_tdata[24]);
          report_field("middle_button", want.middle, out_tdata[25]);
          report_field("right_button", want.right, out_tdata[26]);
        end
      end
      if (in_tvalid && in_tready) begin
        if (track_byte(in_tdata, rep)) cursor_reports.push_back(rep);
      end
    end
    pending = cursor_reports.size();
  end

endmodule

// ===== tb/ps2_mouse_packet_tracker_top_tb.sv =====
`timescale 1ns / 100ps

module ps2_mouse_packet_tracker_top_tb;
  import ps2t_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [31:0]      out_tdata;
  logic             cfg_we;
  logic             cfg_addr;
  logic [DIM_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int reports_seen;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_taken;
  int hold_left;
  int bytes_sent;
  int settings_done;

  logic [7:0] opening_bytes [26] = '{
    8'h00, 8'hF7,             // headers without the always-one bit are dropped
    8'h08, 8'h00, 8'h00,
    8'h0F, 8'hFF, 8'hFF,
    8'h38, 8'h00, 8'h00,      // negative zero byte means -256
    8'hC8, 8'hFF, 8'h01,
    8'hF8, 8'h00, 8'h00,
    8'h18, 8'h80, 8'h7F,
    8'h2D, 8'h01, 8'h80,
    8'hFF, 8'h00, 8'hFF
  };

  ps2_mouse_packet_tracker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ps2_mouse_packet_tracker_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .reports_seen (reports_seen)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #5000000;
    $display("Timeout, cursor words still outstanding: %0d", pending);
    $display("Mismatches found");
    $finish;
  end

  // Receiver side; a long hold-off is counted here once the stimulus asks for one.
  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_request != hold_taken) begin
        hold_left = hold_request;
        hold_taken = hold_request;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // A byte may still sit in the input register after the last word.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    drain_block();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // Mostly well-formed packets with random content, some noise and cut packets.
  task automatic send_traffic(input int n_bytes);
    int good;
    int pick;
    good = 0;
    while (good < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        send_byte(8'($urandom) | 8'h08);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        good += 3;
      end else if (pick < 92) begin
        send_byte(8'($urandom));
      end else begin
        send_byte(8'($urandom) | 8'h08);
        send_byte(8'($urandom));
        good += 2;
      end
    end
  endtask

  initial begin
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_SCREEN_WIDTH;
    cfg_wdata = '0;
    hold_request = 0;
    bytes_sent = 0;
    settings_done = 0;
    send_idle_pct = 21;
    recv_idle_pct = 88;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening packets run with the reset screen size.
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin send_idle_pct = 21; recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        case (regime * 3 + s)
          0: begin w = 13'd8;    h = 13'd16;   end
          1: begin w = 13'd4096; h = 13'd4096; end
          2: begin w = 13'h1FFF; h = 13'h1FFF; end
          3: begin w = 13'd0;    h = 13'd3;    end
          4: begin w = 13'd5;    h = 13'd0;    end
          5: begin w = 13'($urandom_range(8, 4096)); h = 13'($urandom_range(16, 4096)); end
          6: begin w = 13'd640;  h = 13'd17;   end
          7: begin w = 13'($urandom); h = 13'($urandom); end
          default: begin w = 13'd1000; h = 13'd480; end
        endcase
        write_screen(w, h);
        if (regime == 2 && s == 0) begin
          // Cursor side stalls long enough that the block backs up its input.
          hold_request = 400;
          send_traffic(150);
        end
        send_traffic(190);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d mouse bytes over %0d screen sizes, checked %0d cursor words.",
             bytes_sent, settings_done + 1, reports_seen);
    $display("Covered dropped headers, overflow and sign cases, edge clamps and a long stall.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
